// ===== design/vmt_pkg.sv =====
// Shared constants and codes for the virtio-mmio transport register file.
// Used by the channel interfaces and by the top level; depends on nothing.
`timescale 1ns / 1ps

package vmt_pkg;

    // Queue count and the width of a queue index
    localparam int NUM_QUEUES = 8;
    localparam int QIDX_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // Payload field widths
    localparam int OP_W     = 2;
    localparam int OFS_W    = 12;
    localparam int NBYTES_W = 4;
    localparam int WORD_W   = 32;
    localparam int NIDX_W   = 3;
    localparam int QSIZE_W  = 16;
    localparam int ADDR64_W = 64;

    // Item kinds
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_RAISE = 2'd2;

    // Register window offsets
    localparam logic [OFS_W-1:0] OFS_MAGIC          = 12'h000;
    localparam logic [OFS_W-1:0] OFS_VERSION        = 12'h004;
    localparam logic [OFS_W-1:0] OFS_DEVICE_ID      = 12'h008;
    localparam logic [OFS_W-1:0] OFS_VENDOR_ID      = 12'h00C;
    localparam logic [OFS_W-1:0] OFS_DEV_FEAT       = 12'h010;
    localparam logic [OFS_W-1:0] OFS_DEV_FEAT_SEL   = 12'h014;
    localparam logic [OFS_W-1:0] OFS_DRV_FEAT       = 12'h020;
    localparam logic [OFS_W-1:0] OFS_DRV_FEAT_SEL   = 12'h024;
    localparam logic [OFS_W-1:0] OFS_QUEUE_SEL      = 12'h030;
    localparam logic [OFS_W-1:0] OFS_QUEUE_NUM_MAX  = 12'h034;
    localparam logic [OFS_W-1:0] OFS_QUEUE_NUM      = 12'h038;
    localparam logic [OFS_W-1:0] OFS_QUEUE_READY    = 12'h044;
    localparam logic [OFS_W-1:0] OFS_QUEUE_NOTIFY   = 12'h050;
    localparam logic [OFS_W-1:0] OFS_IRQ_STATUS     = 12'h060;
    localparam logic [OFS_W-1:0] OFS_IRQ_ACK        = 12'h064;
    localparam logic [OFS_W-1:0] OFS_STATUS         = 12'h070;
    localparam logic [OFS_W-1:0] OFS_DESC_LOW       = 12'h080;
    localparam logic [OFS_W-1:0] OFS_DESC_HIGH      = 12'h084;
    localparam logic [OFS_W-1:0] OFS_AVAIL_LOW      = 12'h090;
    localparam logic [OFS_W-1:0] OFS_AVAIL_HIGH     = 12'h094;
    localparam logic [OFS_W-1:0] OFS_USED_LOW       = 12'h0A0;
    localparam logic [OFS_W-1:0] OFS_USED_HIGH      = 12'h0A4;
    localparam logic [OFS_W-1:0] OFS_CONFIG_GEN     = 12'h0FC;

    // Fixed identification values
    localparam logic [WORD_W-1:0] MAGIC_WORD   = 32'h7472_6976;
    localparam logic [WORD_W-1:0] MMIO_VERSION = 32'd2;

    // Access widths
    localparam logic [NBYTES_W-1:0] NBYTES_1 = 4'd1;
    localparam logic [NBYTES_W-1:0] NBYTES_2 = 4'd2;
    localparam logic [NBYTES_W-1:0] NBYTES_4 = 4'd4;

    // Configuration port
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;
    localparam int CIDX_W  = 3;

    localparam logic [CIDX_W-1:0] CFG_DEVICE_TYPE = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_VENDOR      = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_FEATURES    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MAX_QSIZE   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_GENERATION  = 3'd4;

    localparam logic [ADDR64_W-1:0] FEATURES_RESET = 64'h0000_0001_0000_0000;
    localparam logic [QSIZE_W-1:0]  MAX_QSIZE_RESET = 16'd256;

endpackage

// ===== design/vmt_req_if.sv =====
// Request channel: one bus read, bus write or interrupt raise per transfer.
// Depends on vmt_pkg for field widths.
`timescale 1ns / 1ps

interface vmt_req_if;
    logic                          valid;
    logic                          ready;
    logic [vmt_pkg::OP_W-1:0]      op;
    logic [vmt_pkg::OFS_W-1:0]     reg_offset;
    logic [vmt_pkg::NBYTES_W-1:0]  access_bytes;
    logic [vmt_pkg::WORD_W-1:0]    write_word;
    logic [vmt_pkg::WORD_W-1:0]    raise_flags;

    modport source (output valid, op, reg_offset, access_bytes, write_word, raise_flags,
                    input ready);
    modport sink (input valid, op, reg_offset, access_bytes, write_word, raise_flags,
                  output ready);
endinterface

// ===== design/vmt_rsp_if.sv =====
// Result channel: one result per request transfer.
// Depends on vmt_pkg for field widths.
`timescale 1ns / 1ps

interface vmt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [vmt_pkg::WORD_W-1:0]  read_word;
    logic                        access_error;
    logic                        notify_valid;
    logic [vmt_pkg::NIDX_W-1:0]  notify_index;
    logic                        device_reset_pulse;
    logic                        irq_raise;
    logic [vmt_pkg::WORD_W-1:0]  pending_irq_bits;

    modport source (output valid, read_word, access_error, notify_valid, notify_index,
                    device_reset_pulse, irq_raise, pending_irq_bits,
                    input ready);
    modport sink (input valid, read_word, access_error, notify_valid, notify_index,
                  device_reset_pulse, irq_raise, pending_irq_bits,
                  output ready);
endinterface

// ===== design/virtio_mmio_transport_regs.sv =====
// Virtio-mmio transport register file: input register, decode, result register.
// Each request is registered in the input stage, then its result in the result register.
// One item per cycle unless results stall, set by the single decode/update pass.
// Reset (rst_n low, asynchronous) empties both stages and clears all transport state;
// configuration registers return to their reset values.
`timescale 1ns / 1ps

module virtio_mmio_transport_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    vmt_req_if.sink                       req,
    vmt_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vmt_pkg::PADDR_W-1:0]   paddr,
    input  logic [vmt_pkg::PDATA_W-1:0]   pwdata,
    output logic [vmt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int NQ = vmt_pkg::NUM_QUEUES;
    localparam int QW = vmt_pkg::QIDX_W;
    localparam int WW = vmt_pkg::WORD_W;
    localparam int AW = vmt_pkg::ADDR64_W;
    localparam int SW = vmt_pkg::QSIZE_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WW-1:0] device_type_id_reg;
    logic [WW-1:0] vendor_code_reg;
    logic [AW-1:0] offered_features_reg;
    logic [SW-1:0] max_queue_size_reg;
    logic [WW-1:0] generation_count_reg;

    logic                       cfg_write;
    logic [vmt_pkg::CIDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[vmt_pkg::PADDR_W-1:3];

    // Write a configuration register at the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_type_id_reg   <= '0;
            vendor_code_reg      <= '0;
            offered_features_reg <= vmt_pkg::FEATURES_RESET;
            max_queue_size_reg   <= vmt_pkg::MAX_QSIZE_RESET;
            generation_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                vmt_pkg::CFG_DEVICE_TYPE: device_type_id_reg   <= pwdata[WW-1:0];
                vmt_pkg::CFG_VENDOR:      vendor_code_reg      <= pwdata[WW-1:0];
                vmt_pkg::CFG_FEATURES:    offered_features_reg <= pwdata;
                vmt_pkg::CFG_MAX_QSIZE:   max_queue_size_reg   <= pwdata[SW-1:0];
                vmt_pkg::CFG_GENERATION:  generation_count_reg <= pwdata[WW-1:0];
                default:                  ;
            endcase
        end
    end

    // Read back a configuration register
    always_comb
    begin
        unique case (cfg_idx)
            vmt_pkg::CFG_DEVICE_TYPE: prdata = {32'b0, device_type_id_reg};
            vmt_pkg::CFG_VENDOR:      prdata = {32'b0, vendor_code_reg};
            vmt_pkg::CFG_FEATURES:    prdata = offered_features_reg;
            vmt_pkg::CFG_MAX_QSIZE:   prdata = {48'b0, max_queue_size_reg};
            vmt_pkg::CFG_GENERATION:  prdata = {32'b0, generation_count_reg};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic req_fire;
    logic advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        s1_valid_next  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request payload
    logic [vmt_pkg::OP_W-1:0]     s1_op_reg;
    logic [vmt_pkg::OFS_W-1:0]    s1_offset_reg;
    logic [vmt_pkg::NBYTES_W-1:0] s1_nbytes_reg;
    logic [WW-1:0]                s1_wdata_reg;
    logic [WW-1:0]                s1_flags_reg;

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_op_reg     <= req.op;
            s1_offset_reg <= req.reg_offset;
            s1_nbytes_reg <= req.access_bytes;
            s1_wdata_reg  <= req.write_word;
            s1_flags_reg  <= req.raise_flags;
        end
    end

    // ------------------------------------------------------------------
    // Transport state
    // ------------------------------------------------------------------
    logic [WW-1:0] dev_feat_select_reg,   dev_feat_select_next;
    logic [WW-1:0] drv_feat_select_reg,   drv_feat_select_next;
    logic [AW-1:0] accepted_features_reg, accepted_features_next;
    logic [WW-1:0] selected_queue_reg,    selected_queue_next;
    logic [SW-1:0] queue_size_reg        [NQ];
    logic [SW-1:0] queue_size_next       [NQ];
    logic [NQ-1:0] queue_ready_reg,       queue_ready_next;
    logic [AW-1:0] desc_ring_addr_reg    [NQ];
    logic [AW-1:0] desc_ring_addr_next   [NQ];
    logic [AW-1:0] avail_ring_addr_reg   [NQ];
    logic [AW-1:0] avail_ring_addr_next  [NQ];
    logic [AW-1:0] used_ring_addr_reg    [NQ];
    logic [AW-1:0] used_ring_addr_next   [NQ];
    logic [WW-1:0] irq_status_bits_reg,   irq_status_bits_next;
    logic [WW-1:0] device_status_reg,     device_status_next;

    // ------------------------------------------------------------------
    // Decode and update
    // ------------------------------------------------------------------
    logic          is_cfg_space;
    logic          width_ok;
    logic          is_bus;
    logic          do_read;
    logic          do_write;
    logic          qok;
    logic [QW-1:0] q;
    logic [WW-1:0] rd_data;
    logic          reset_hit;
    logic          notify_hit;

    assign is_cfg_space = (s1_offset_reg[vmt_pkg::OFS_W-1:8] != '0);
    assign width_ok     = is_cfg_space ?
                          (s1_nbytes_reg == vmt_pkg::NBYTES_1 ||
                           s1_nbytes_reg == vmt_pkg::NBYTES_2 ||
                           s1_nbytes_reg == vmt_pkg::NBYTES_4) :
                          (s1_nbytes_reg == vmt_pkg::NBYTES_4);
    assign is_bus       = (s1_op_reg == vmt_pkg::OP_READ) || (s1_op_reg == vmt_pkg::OP_WRITE);
    assign do_read      = (s1_op_reg == vmt_pkg::OP_READ)  && width_ok && !is_cfg_space;
    assign do_write     = (s1_op_reg == vmt_pkg::OP_WRITE) && width_ok && !is_cfg_space;
    assign qok          = (selected_queue_reg < WW'(NQ));
    assign q            = selected_queue_reg[QW-1:0];

    // Select read data for the addressed register
    always_comb
    begin
        unique case (s1_offset_reg)
            vmt_pkg::OFS_MAGIC:         rd_data = vmt_pkg::MAGIC_WORD;
            vmt_pkg::OFS_VERSION:       rd_data = vmt_pkg::MMIO_VERSION;
            vmt_pkg::OFS_DEVICE_ID:     rd_data = device_type_id_reg;
            vmt_pkg::OFS_VENDOR_ID:     rd_data = vendor_code_reg;
            vmt_pkg::OFS_DEV_FEAT:
            begin
                priority if (dev_feat_select_reg == 32'd0)
                    rd_data = offered_features_reg[WW-1:0];
                else if (dev_feat_select_reg == 32'd1)
                    rd_data = offered_features_reg[AW-1:WW];
                else
                    rd_data = '0;
            end
            vmt_pkg::OFS_DEV_FEAT_SEL:  rd_data = dev_feat_select_reg;
            vmt_pkg::OFS_DRV_FEAT_SEL:  rd_data = drv_feat_select_reg;
            vmt_pkg::OFS_QUEUE_SEL:     rd_data = selected_queue_reg;
            vmt_pkg::OFS_QUEUE_NUM_MAX: rd_data = qok ? {16'b0, max_queue_size_reg} : '0;
            vmt_pkg::OFS_QUEUE_NUM:     rd_data = qok ? {16'b0, queue_size_reg[q]} : '0;
            vmt_pkg::OFS_QUEUE_READY:   rd_data = qok ? {31'b0, queue_ready_reg[q]} : '0;
            vmt_pkg::OFS_IRQ_STATUS:    rd_data = irq_status_bits_reg;
            vmt_pkg::OFS_STATUS:        rd_data = device_status_reg;
            vmt_pkg::OFS_CONFIG_GEN:    rd_data = generation_count_reg;
            default:                    rd_data = '0;
        endcase
    end

    // Work out the next state for a write or a raise
    always_comb
    begin
        dev_feat_select_next   = dev_feat_select_reg;
        drv_feat_select_next   = drv_feat_select_reg;
        accepted_features_next = accepted_features_reg;
        selected_queue_next    = selected_queue_reg;
        queue_size_next        = queue_size_reg;
        queue_ready_next       = queue_ready_reg;
        desc_ring_addr_next    = desc_ring_addr_reg;
        avail_ring_addr_next   = avail_ring_addr_reg;
        used_ring_addr_next    = used_ring_addr_reg;
        irq_status_bits_next   = irq_status_bits_reg;
        device_status_next     = device_status_reg;
        reset_hit              = 1'b0;
        notify_hit             = 1'b0;

        if (s1_op_reg == vmt_pkg::OP_RAISE)
        begin
            irq_status_bits_next = irq_status_bits_reg | s1_flags_reg;
        end
        else if (do_write)
        begin
            unique case (s1_offset_reg)
                vmt_pkg::OFS_DEV_FEAT_SEL: dev_feat_select_next = s1_wdata_reg;
                vmt_pkg::OFS_DRV_FEAT:
                begin
                    priority if (drv_feat_select_reg == 32'd0)
                        accepted_features_next[WW-1:0] = s1_wdata_reg;
                    else if (drv_feat_select_reg == 32'd1)
                        accepted_features_next[AW-1:WW] = s1_wdata_reg;
                    else
                        accepted_features_next = accepted_features_reg;
                end
                vmt_pkg::OFS_DRV_FEAT_SEL: drv_feat_select_next = s1_wdata_reg;
                vmt_pkg::OFS_QUEUE_SEL:    selected_queue_next  = s1_wdata_reg;
                vmt_pkg::OFS_QUEUE_NUM:
                begin
                    if (qok && (s1_wdata_reg <= {16'b0, max_queue_size_reg}))
                        queue_size_next[q] = s1_wdata_reg[SW-1:0];
                end
                vmt_pkg::OFS_QUEUE_READY:
                begin
                    if (qok)
                        queue_ready_next[q] = s1_wdata_reg[0];
                end
                vmt_pkg::OFS_QUEUE_NOTIFY:
                    notify_hit = (s1_wdata_reg < WW'(NQ));
                vmt_pkg::OFS_IRQ_ACK:
                    irq_status_bits_next = irq_status_bits_reg & ~s1_wdata_reg;
                vmt_pkg::OFS_STATUS:
                begin
                    if (s1_wdata_reg == '0)
                    begin
                        // Device reset: drop status, pending interrupts and ready flags
                        reset_hit            = 1'b1;
                        device_status_next   = '0;
                        irq_status_bits_next = '0;
                        queue_ready_next     = '0;
                    end
                    else
                    begin
                        device_status_next = s1_wdata_reg;
                    end
                end
                vmt_pkg::OFS_DESC_LOW:   if (qok) desc_ring_addr_next[q][WW-1:0]   = s1_wdata_reg;
                vmt_pkg::OFS_DESC_HIGH:  if (qok) desc_ring_addr_next[q][AW-1:WW]  = s1_wdata_reg;
                vmt_pkg::OFS_AVAIL_LOW:  if (qok) avail_ring_addr_next[q][WW-1:0]  = s1_wdata_reg;
                vmt_pkg::OFS_AVAIL_HIGH: if (qok) avail_ring_addr_next[q][AW-1:WW] = s1_wdata_reg;
                vmt_pkg::OFS_USED_LOW:   if (qok) used_ring_addr_next[q][WW-1:0]   = s1_wdata_reg;
                vmt_pkg::OFS_USED_HIGH:  if (qok) used_ring_addr_next[q][AW-1:WW]  = s1_wdata_reg;
                default:                 ;
            endcase
        end
    end

    // Commit the state as the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_feat_select_reg   <= '0;
            drv_feat_select_reg   <= '0;
            accepted_features_reg <= '0;
            selected_queue_reg    <= '0;
            queue_ready_reg       <= '0;
            irq_status_bits_reg   <= '0;
            device_status_reg     <= '0;
            for (int i = 0; i < NQ; i++)
            begin
                queue_size_reg[i]      <= '0;
                desc_ring_addr_reg[i]  <= '0;
                avail_ring_addr_reg[i] <= '0;
                used_ring_addr_reg[i]  <= '0;
            end
        end
        else if (advance)
        begin
            dev_feat_select_reg   <= dev_feat_select_next;
            drv_feat_select_reg   <= drv_feat_select_next;
            accepted_features_reg <= accepted_features_next;
            selected_queue_reg    <= selected_queue_next;
            queue_ready_reg       <= queue_ready_next;
            irq_status_bits_reg   <= irq_status_bits_next;
            device_status_reg     <= device_status_next;
            queue_size_reg        <= queue_size_next;
            desc_ring_addr_reg    <= desc_ring_addr_next;
            avail_ring_addr_reg   <= avail_ring_addr_next;
            used_ring_addr_reg    <= used_ring_addr_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [WW-1:0]              out_rdata_reg;
    logic                       out_err_reg;
    logic                       out_notify_reg;
    logic [vmt_pkg::NIDX_W-1:0] out_nidx_reg;
    logic                       out_reset_reg;
    logic                       out_irq_reg;
    logic [WW-1:0]              out_pending_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_rdata_reg   <= do_read ? rd_data : '0;
            out_err_reg     <= is_bus && !width_ok;
            out_notify_reg  <= notify_hit;
            out_nidx_reg    <= notify_hit ? s1_wdata_reg[vmt_pkg::NIDX_W-1:0] : '0;
            out_reset_reg   <= reset_hit;
            out_irq_reg     <= (s1_op_reg == vmt_pkg::OP_RAISE);
            out_pending_reg <= irq_status_bits_next;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.read_word          = out_rdata_reg;
    assign rsp.access_error       = out_err_reg;
    assign rsp.notify_valid       = out_notify_reg;
    assign rsp.notify_index       = out_nidx_reg;
    assign rsp.device_reset_pulse = out_reset_reg;
    assign rsp.irq_raise          = out_irq_reg;
    assign rsp.pending_irq_bits   = out_pending_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_reset_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.device_reset_pulse |-> rsp.pending_irq_bits == '0)
        else $error("device reset result with interrupts still pending");

    a_raise_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.irq_raise |->
            !rsp.access_error && !rsp.notify_valid && !rsp.device_reset_pulse &&
            rsp.read_word == '0)
        else $error("raise result carries bus access fields");

    a_error_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.access_error |->
            !rsp.notify_valid && !rsp.device_reset_pulse && rsp.read_word == '0)
        else $error("failed access produced an effect");

    a_reset_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        advance && reset_hit |=> queue_ready_reg == '0 && device_status_reg == '0)
        else $error("device reset left a queue ready or status set");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> s1_valid_reg && out_valid_reg && !rsp.ready)
        else $error("request side stalled with room in the pipeline");

endmodule

// ===== bench/virtio_mmio_transport_regs_test.sv =====
// Self-checking bench for the virtio-mmio transport register file: drives bus
// accesses and interrupt raises, predicts every result and checks it field by field.
// Depends on vmt_pkg, vmt_req_if, vmt_rsp_if and virtio_mmio_transport_regs.
`timescale 1ns / 1ps

module virtio_mmio_transport_regs_test;

    localparam logic [vmt_pkg::OP_W-1:0]  OP_UNUSED      = 2'd3;
    localparam logic [vmt_pkg::OFS_W-1:0] CFG_SPACE_BASE = 12'h100;
    localparam logic [vmt_pkg::OFS_W-1:0] OFS_UNASSIGNED = 12'h0F8;
    localparam int                        DRAIN_CYCLES   = 6;
    localparam int                        LONG_HOLD      = 200;
    localparam int                        PHASE_ITEMS    = 140;

    typedef struct packed {
        logic [vmt_pkg::OP_W-1:0]     op;
        logic [vmt_pkg::OFS_W-1:0]    reg_offset;
        logic [vmt_pkg::NBYTES_W-1:0] access_bytes;
        logic [vmt_pkg::WORD_W-1:0]   write_word;
        logic [vmt_pkg::WORD_W-1:0]   raise_flags;
    } reg_access_t;

    typedef struct packed {
        logic [vmt_pkg::WORD_W-1:0] read_word;
        logic                       access_error;
        logic                       notify_valid;
        logic [vmt_pkg::NIDX_W-1:0] notify_index;
        logic                       device_reset_pulse;
        logic                       irq_raise;
        logic [vmt_pkg::WORD_W-1:0] pending_irq_bits;
    } reg_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [vmt_pkg::PADDR_W-1:0]  paddr;
    logic [vmt_pkg::PDATA_W-1:0]  pwdata;
    logic [vmt_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    vmt_req_if req_ch ();
    vmt_rsp_if rsp_ch ();

    virtio_mmio_transport_regs i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted transport state and settings (reset values)
    logic [vmt_pkg::WORD_W-1:0]   feat_sel_dev    = '0;
    logic [vmt_pkg::WORD_W-1:0]   feat_sel_drv    = '0;
    logic [vmt_pkg::WORD_W-1:0]   chosen_queue    = '0;
    logic [vmt_pkg::QSIZE_W-1:0]  q_size [vmt_pkg::NUM_QUEUES] = '{default: '0};
    bit                           q_ready [vmt_pkg::NUM_QUEUES] = '{default: 1'b0};
    logic [vmt_pkg::WORD_W-1:0]   irq_pending     = '0;
    logic [vmt_pkg::WORD_W-1:0]   status_reg      = '0;
    logic [vmt_pkg::WORD_W-1:0]   cfg_device_type = '0;
    logic [vmt_pkg::WORD_W-1:0]   cfg_vendor      = '0;
    logic [vmt_pkg::ADDR64_W-1:0] cfg_features    = vmt_pkg::FEATURES_RESET;
    logic [vmt_pkg::QSIZE_W-1:0]  cfg_max_qsize   = vmt_pkg::MAX_QSIZE_RESET;
    logic [vmt_pkg::WORD_W-1:0]   cfg_generation  = '0;

    reg_access_t access_queue [$];
    reg_result_t predicted_results [$];
    reg_access_t offer;
    reg_result_t want;

    int unsigned items_pushed    = 0;
    int unsigned results_matched = 0;
    int unsigned mismatches      = 0;
    int unsigned src_idle_pct    = 0;
    int unsigned snk_stall_pct   = 0;
    int unsigned width_fault_pct = 0;
    bit          hold_request    = 1'b0;
    bit          hold_active     = 1'b0;

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the result of one accepted transfer and advance the predicted state.
    // Ring addresses and the driver feature word are write-only and never reach the
    // outputs, so their writes leave no trace here.
    function automatic reg_result_t predict_access(reg_access_t it);
        reg_result_t                r;
        logic                       width_ok;
        logic                       queue_ok;
        logic [vmt_pkg::QIDX_W-1:0] q;
        logic [vmt_pkg::WORD_W-1:0] wd;
        r = '0;
        wd = it.write_word;
        queue_ok = (chosen_queue < vmt_pkg::NUM_QUEUES);
        q = queue_ok ? chosen_queue[vmt_pkg::QIDX_W-1:0] : '0;
        if (it.op == vmt_pkg::OP_RAISE)
        begin
            irq_pending = irq_pending | it.raise_flags;
            r.irq_raise = 1'b1;
        end
        else if (it.op == vmt_pkg::OP_READ || it.op == vmt_pkg::OP_WRITE)
        begin
            if (it.reg_offset < CFG_SPACE_BASE)
                width_ok = (it.access_bytes == vmt_pkg::NBYTES_4);
            else
                width_ok = (it.access_bytes == vmt_pkg::NBYTES_1) ||
                           (it.access_bytes == vmt_pkg::NBYTES_2) ||
                           (it.access_bytes == vmt_pkg::NBYTES_4);
            if (!width_ok)
                r.access_error = 1'b1;
            else if (it.reg_offset < CFG_SPACE_BASE && it.op == vmt_pkg::OP_READ)
            begin
                case (it.reg_offset)
                    vmt_pkg::OFS_MAGIC:         r.read_word = vmt_pkg::MAGIC_WORD;
                    vmt_pkg::OFS_VERSION:       r.read_word = vmt_pkg::MMIO_VERSION;
                    vmt_pkg::OFS_DEVICE_ID:     r.read_word = cfg_device_type;
                    vmt_pkg::OFS_VENDOR_ID:     r.read_word = cfg_vendor;
                    vmt_pkg::OFS_DEV_FEAT:
                        if (feat_sel_dev == 0)
                            r.read_word = cfg_features[31:0];
                        else if (feat_sel_dev == 1)
                            r.read_word = cfg_features[63:32];
                    vmt_pkg::OFS_DEV_FEAT_SEL:  r.read_word = feat_sel_dev;
                    vmt_pkg::OFS_DRV_FEAT_SEL:  r.read_word = feat_sel_drv;
                    vmt_pkg::OFS_QUEUE_SEL:     r.read_word = chosen_queue;
                    vmt_pkg::OFS_QUEUE_NUM_MAX:
                        r.read_word = queue_ok ? 32'(cfg_max_qsize) : '0;
                    vmt_pkg::OFS_QUEUE_NUM:
                        r.read_word = queue_ok ? 32'(q_size[q]) : '0;
                    vmt_pkg::OFS_QUEUE_READY:
                        r.read_word = queue_ok ? 32'(q_ready[q]) : '0;
                    vmt_pkg::OFS_IRQ_STATUS:    r.read_word = irq_pending;
                    vmt_pkg::OFS_STATUS:        r.read_word = status_reg;
                    vmt_pkg::OFS_CONFIG_GEN:    r.read_word = cfg_generation;
                    default:                    r.read_word = '0;
                endcase
            end
            else if (it.reg_offset < CFG_SPACE_BASE)
            begin
                case (it.reg_offset)
                    vmt_pkg::OFS_DEV_FEAT_SEL: feat_sel_dev = wd;
                    vmt_pkg::OFS_DRV_FEAT_SEL: feat_sel_drv = wd;
                    vmt_pkg::OFS_QUEUE_SEL:    chosen_queue = wd;
                    vmt_pkg::OFS_QUEUE_NUM:
                        if (queue_ok && wd <= 32'(cfg_max_qsize))
                            q_size[q] = wd[vmt_pkg::QSIZE_W-1:0];
                    vmt_pkg::OFS_QUEUE_READY:
                        if (queue_ok)
                            q_ready[q] = wd[0];
                    vmt_pkg::OFS_QUEUE_NOTIFY:
                        if (wd < vmt_pkg::NUM_QUEUES)
                        begin
                            r.notify_valid = 1'b1;
                            r.notify_index = wd[vmt_pkg::NIDX_W-1:0];
                        end
                    vmt_pkg::OFS_IRQ_ACK:      irq_pending = irq_pending & ~wd;
                    vmt_pkg::OFS_STATUS:
                        if (wd == 0)
                        begin
                            // device reset: drop status, interrupts and ready flags
                            status_reg = '0;
                            irq_pending = '0;
                            q_ready = '{default: 1'b0};
                            r.device_reset_pulse = 1'b1;
                        end
                        else
                            status_reg = wd;
                    default: ;
                endcase
            end
        end
        r.pending_irq_bits = irq_pending;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] got, logic [63:0] exp_val);
        if (got !== exp_val)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected %h, got %h", name, exp_val, got);
        end
    endtask

    // Queue one transfer; a share of register accesses gets a random width
    task automatic add_item(logic [vmt_pkg::OP_W-1:0] op, logic [vmt_pkg::OFS_W-1:0] ofs,
                            logic [vmt_pkg::WORD_W-1:0] data,
                            logic [vmt_pkg::NBYTES_W-1:0] nbytes = vmt_pkg::NBYTES_4);
        reg_access_t it;
        if (nbytes == vmt_pkg::NBYTES_4 && op != vmt_pkg::OP_RAISE &&
            $urandom_range(99) < width_fault_pct)
            nbytes = 4'($urandom_range(1, 8));
        it.op = op;
        it.reg_offset = ofs;
        it.access_bytes = nbytes;
        it.write_word = (op == vmt_pkg::OP_RAISE) ? $urandom() : data;
        it.raise_flags = (op == vmt_pkg::OP_RAISE) ? data : $urandom();
        access_queue.push_back(it);
        items_pushed++;
    endtask

    // One driver-like sequence with random content, or a little noise
    task automatic queue_random_scenario();
        int unsigned                pick;
        int unsigned                n;
        logic [vmt_pkg::WORD_W-1:0] v;
        logic [vmt_pkg::OFS_W-1:0]  ofs;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            // queue set-up: select, size, rings, ready, notify
            v = ($urandom_range(0, 9) != 0) ? $urandom_range(0, vmt_pkg::NUM_QUEUES - 1) :
                ($urandom_range(0, 1) ? vmt_pkg::NUM_QUEUES : $urandom());
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_QUEUE_SEL, v);
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_QUEUE_NUM_MAX, $urandom());
            v = ($urandom_range(0, 4) == 0) ? $urandom() :
                $urandom_range(0, cfg_max_qsize + 1);
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_QUEUE_NUM, v);
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_QUEUE_NUM, $urandom());
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_DESC_LOW, $urandom());
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_DESC_HIGH, $urandom());
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_AVAIL_LOW, $urandom());
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_AVAIL_HIGH, $urandom());
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_USED_LOW, $urandom());
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_USED_HIGH, $urandom());
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_DESC_LOW, $urandom());
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_QUEUE_READY, $urandom());
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_QUEUE_READY, $urandom());
            v = ($urandom_range(0, 4) == 0) ? $urandom() :
                $urandom_range(0, vmt_pkg::NUM_QUEUES);
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_QUEUE_NOTIFY, v);
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_QUEUE_SEL, $urandom());
        end
        else if (pick < 50)
        begin
            // feature negotiation through the select registers
            v = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 2);
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_DEV_FEAT_SEL, v);
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_DEV_FEAT, $urandom());
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_DEV_FEAT_SEL, $urandom());
            v = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 2);
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_DRV_FEAT_SEL, v);
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_DRV_FEAT, $urandom());
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_DRV_FEAT, $urandom());
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_DRV_FEAT_SEL, $urandom());
        end
        else if (pick < 70)
        begin
            // interrupt raise, status read, acknowledge
            v = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31)) : $urandom();
            add_item(vmt_pkg::OP_RAISE, vmt_pkg::OFS_MAGIC, v);
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_IRQ_STATUS, $urandom());
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_IRQ_ACK,
                     $urandom_range(0, 1) ? v : $urandom());
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_IRQ_STATUS, $urandom());
        end
        else if (pick < 85)
        begin
            // status handling and identification reads
            add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_STATUS,
                     ($urandom_range(0, 3) == 0) ? '0 : $urandom());
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_STATUS, $urandom());
            add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_QUEUE_READY, $urandom());
            case ($urandom_range(0, 4))
                0: ofs = vmt_pkg::OFS_MAGIC;
                1: ofs = vmt_pkg::OFS_VERSION;
                2: ofs = vmt_pkg::OFS_DEVICE_ID;
                3: ofs = vmt_pkg::OFS_VENDOR_ID;
                default: ofs = vmt_pkg::OFS_CONFIG_GEN;
            endcase
            add_item(vmt_pkg::OP_READ, ofs, $urandom());
        end
        else
        begin
            // noise: anything in the window, config space included
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                if ($urandom_range(0, 1))
                    add_item(2'($urandom_range(0, 3)),
                             12'($urandom_range(CFG_SPACE_BASE, 4095)), $urandom(),
                             vmt_pkg::NBYTES_1 << $urandom_range(0, 2));
                else
                    add_item(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                             $urandom(), 4'($urandom_range(1, 8)));
            end
        end
    endtask

    // Hold until every queued transfer has its result, then let the pipe settle
    task automatic drain_results();
        do
            @(posedge clk);
        while (results_matched != items_pushed);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one setting over the configuration port, then read it back
    task automatic write_setting(logic [vmt_pkg::CIDX_W-1:0] idx,
                                 logic [vmt_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            vmt_pkg::CFG_DEVICE_TYPE: cfg_device_type = value[31:0];
            vmt_pkg::CFG_VENDOR:      cfg_vendor = value[31:0];
            vmt_pkg::CFG_FEATURES:    cfg_features = value;
            vmt_pkg::CFG_MAX_QSIZE:   cfg_max_qsize = value[vmt_pkg::QSIZE_W-1:0];
            vmt_pkg::CFG_GENERATION:  cfg_generation = value[31:0];
            default:                  ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("config readback", prdata, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(logic [31:0] dev_type, logic [31:0] vendor,
                                  logic [63:0] features, logic [15:0] max_qsize,
                                  logic [31:0] generation);
        write_setting(vmt_pkg::CFG_DEVICE_TYPE, 64'(dev_type));
        write_setting(vmt_pkg::CFG_VENDOR, 64'(vendor));
        write_setting(vmt_pkg::CFG_FEATURES, features);
        write_setting(vmt_pkg::CFG_MAX_QSIZE, 64'(max_qsize));
        write_setting(vmt_pkg::CFG_GENERATION, 64'(generation));
    endtask

    // One phase of random traffic; under pressure the receiver holds off at the
    // start and the sender pauses halfway until everything has come back
    task automatic run_phase(int unsigned src_pct, int unsigned snk_pct, bit pressure);
        int unsigned target;
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        width_fault_pct = 5;
        target = items_pushed + PHASE_ITEMS;
        if (pressure)
            hold_request = 1'b1;
        while (items_pushed < target - (pressure ? PHASE_ITEMS / 2 : 0))
            queue_random_scenario();
        if (pressure)
            drain_results();
        while (items_pushed < target)
            queue_random_scenario();
        drain_results();
    endtask

    // Driver: offer queued transfers, hold each until accepted
    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid)
                predicted_results.push_back(predict_access(offer));
            if (access_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                offer = access_queue.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.op           <= offer.op;
                req_ch.reg_offset   <= offer.reg_offset;
                req_ch.access_bytes <= offer.access_bytes;
                req_ch.write_word   <= offer.write_word;
                req_ch.raise_flags  <= offer.raise_flags;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("MISMATCH result with no transfer outstanding");
                end
                else
                begin
                    want = predicted_results.pop_front();
                    results_matched++;
                    check_field("read_word", 64'(rsp_ch.read_word), 64'(want.read_word));
                    check_field("access_error", 64'(rsp_ch.access_error),
                                64'(want.access_error));
                    check_field("notify_valid", 64'(rsp_ch.notify_valid),
                                64'(want.notify_valid));
                    check_field("notify_index", 64'(rsp_ch.notify_index),
                                64'(want.notify_index));
                    check_field("device_reset_pulse", 64'(rsp_ch.device_reset_pulse),
                                64'(want.device_reset_pulse));
                    check_field("irq_raise", 64'(rsp_ch.irq_raise), 64'(want.irq_raise));
                    check_field("pending_irq_bits", 64'(rsp_ch.pending_irq_bits),
                                64'(want.pending_irq_bits));
                end
            end
            rsp_ch.ready <= !hold_active && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Receiver hold-off: drop ready for a long stretch once asked
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Sequencer: reset, directed checks, then random phases over several settings
    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.op           = vmt_pkg::OP_READ;
        req_ch.reg_offset   = '0;
        req_ch.access_bytes = vmt_pkg::NBYTES_4;
        req_ch.write_word   = '0;
        req_ch.raise_flags  = '0;
        rsp_ch.ready        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: identification, feature select past one, queue select out of
        // range, oversized queue size, missing-queue notify, device reset, width
        // errors, config space, write-only reads and the unused op
        add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_MAGIC, '0);
        add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_VERSION, '0);
        add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_DEVICE_ID, '0);
        add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_DEV_FEAT, '0);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_DEV_FEAT_SEL, 32'd1);
        add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_DEV_FEAT, '0);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_DEV_FEAT_SEL, 32'd2);
        add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_DEV_FEAT, '0);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_DRV_FEAT_SEL, 32'd2);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_DRV_FEAT, '1);
        add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_DRV_FEAT, '0);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_QUEUE_SEL, vmt_pkg::NUM_QUEUES);
        add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_QUEUE_NUM_MAX, '0);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_QUEUE_SEL, vmt_pkg::NUM_QUEUES - 1);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_QUEUE_NUM,
                 32'(vmt_pkg::MAX_QSIZE_RESET) + 32'd1);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_QUEUE_NUM, 32'(vmt_pkg::MAX_QSIZE_RESET));
        add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_QUEUE_NUM, '0);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_QUEUE_READY, 32'd1);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_QUEUE_NOTIFY, vmt_pkg::NUM_QUEUES - 1);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_QUEUE_NOTIFY, vmt_pkg::NUM_QUEUES);
        add_item(vmt_pkg::OP_RAISE, vmt_pkg::OFS_MAGIC, '1);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_IRQ_ACK, 32'h0000_FFFF);
        add_item(vmt_pkg::OP_WRITE, vmt_pkg::OFS_STATUS, '0);
        add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_QUEUE_READY, '0);
        add_item(vmt_pkg::OP_READ, vmt_pkg::OFS_DEVICE_ID, '0, vmt_pkg::NBYTES_2);
        add_item(vmt_pkg::OP_WRITE, CFG_SPACE_BASE, '1, vmt_pkg::NBYTES_1);
        add_item(vmt_pkg::OP_READ, 12'hFFF, '0, 4'd8);
        add_item(vmt_pkg::OP_READ, OFS_UNASSIGNED, '0);
        add_item(OP_UNUSED, vmt_pkg::OFS_STATUS, '0);
        drain_results();

        // All-zero settings, no idling
        apply_settings('0, '0, '0, '0, '0);
        run_phase(0, 0, 1'b0);
        // All-ones settings but for the max queue size, sender idling
        apply_settings('1, '1, '1, 16'd32768, '1);
        run_phase(51, 0, 1'b0);
        // Random settings, receiver stalling
        apply_settings($urandom(), $urandom(), {$urandom(), $urandom()},
                       16'($urandom_range(1, 600)), $urandom());
        run_phase(0, 51, 1'b0);
        // Random settings, both sides idling
        apply_settings($urandom(), $urandom(), {$urandom(), $urandom()},
                       16'($urandom_range(0, 32768)), $urandom());
        run_phase(24, 24, 1'b0);
        // Reset-like settings under back-pressure
        apply_settings($urandom(), $urandom(), vmt_pkg::FEATURES_RESET,
                       vmt_pkg::MAX_QSIZE_RESET, $urandom());
        run_phase(0, 0, 1'b1);

        $display("Checked %0d results from %0d transfers over six register settings",
                 results_matched, items_pushed);
        $display("Idling on both sides, a %0d-cycle receiver hold-off and a sender pause",
                 LONG_HOLD);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
